// ===== rtl/matrix_multiply_engine_defines.svh =====
// ----------------------------------------------------------------------------
// matrix multiply engine assertion macros
// shared check forms for the engine's concurrent assertions
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// property checked on every clock, masked while reset is high
`define MME_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define MME_IMPLY(lbl, ante, cons, msg) \
  `MME_CHECK(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// types, codes and helpers shared by the matrix multiply engine
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DIM_CAP     = 8;   // row and column fields are 3 bits wide
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 35;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } mme_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FEED,
    ST_DRAIN,
    ST_EMIT,
    ST_ERR
  } mme_state_t;

  // one term of a dot product moving down the cell chain
  typedef struct packed {
    logic                    valid;
    logic [2:0]              k;
    logic signed [VAL_W-1:0] a;
  } mme_link_t;

  // sequencer controls for the cell chain
  typedef struct packed {
    logic                    clear;
    logic                    shift;
    logic                    b_we;
    logic [2:0]              b_row;
    logic [2:0]              b_col;
    logic signed [VAL_W-1:0] b_data;
  } mme_ctrl_t;

  // dimension register as used: zero counts as one, clipped at the limit
  function automatic logic [3:0] eff_dim(input logic [3:0] v, input logic [3:0] lim);
    logic [3:0] r;
    r = v;
    if (r == 4'd0) begin
      r = 4'd1;
    end
    if (r > lim) begin
      r = lim;
    end
    return r;
  endfunction

endpackage

// ===== rtl/mme_cell.sv =====
// ----------------------------------------------------------------------------
// mme_cell
// one column of the product: holds a column of B, multiplies and accumulates
// ----------------------------------------------------------------------------
module mme_cell #(
  parameter int DLIM = mme_pkg::DIM_CAP
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               shift,
  input  logic                               b_we,
  input  logic [2:0]                         b_row,
  input  logic signed [mme_pkg::VAL_W-1:0]   b_data,
  input  mme_pkg::mme_link_t                 link_in,
  output mme_pkg::mme_link_t                 link_out,
  input  logic signed [mme_pkg::ACC_W-1:0]   acc_in,
  output logic signed [mme_pkg::ACC_W-1:0]   acc_out
);

  localparam int KW = (DLIM > 1) ? $clog2(DLIM) : 1;

  logic signed [mme_pkg::VAL_W-1:0]  b_store [DLIM];
  mme_pkg::mme_link_t                link;
  logic signed [mme_pkg::PROD_W-1:0] prod;
  logic                              prod_valid;
  logic signed [mme_pkg::ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_store[b_row[KW-1:0]] <= b_data;
    end
  end

  // term register, also handed on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      link.valid <= 1'b0;
    end else begin
      link.valid <= link_in.valid;
    end
    link.k <= link_in.k;
    link.a <= link_in.a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= link.valid;
    end
    prod <= link.a * b_store[link.k[KW-1:0]];
  end

  // clear at row start, shift toward the head while unloading
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (shift) begin
      acc <= acc_in;
    end else if (prod_valid) begin
      acc <= acc + {{(mme_pkg::ACC_W-mme_pkg::PROD_W){prod[mme_pkg::PROD_W-1]}}, prod};
    end
  end

  assign link_out = link;
  assign acc_out  = acc;

endmodule

// ===== rtl/mme_chain.sv =====
// ----------------------------------------------------------------------------
// mme_chain
// row of product cells; terms of A travel down, sums shift back to the head
// ----------------------------------------------------------------------------
module mme_chain #(
  parameter int DLIM = mme_pkg::DIM_CAP
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mme_pkg::mme_ctrl_t                 ctrl,
  input  mme_pkg::mme_link_t                 head_in,
  output logic signed [mme_pkg::ACC_W-1:0]   head_acc,
  output logic                               tail_valid
);

  mme_pkg::mme_link_t               links [DLIM];
  logic signed [mme_pkg::ACC_W-1:0] accs  [DLIM+1];

  assign accs[DLIM] = '0;

  for (genvar j = 0; j < DLIM; j++) begin : g_cell
    mme_pkg::mme_link_t lin;
    logic               we;

    if (j == 0) begin : g_head
      assign lin = head_in;
    end else begin : g_body
      assign lin = links[j-1];
    end

    assign we = ctrl.b_we && (ctrl.b_col == 3'(j));

    mme_cell #(
      .DLIM(DLIM)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (ctrl.clear),
      .shift    (ctrl.shift),
      .b_we     (we),
      .b_row    (ctrl.b_row),
      .b_data   (ctrl.b_data),
      .link_in  (lin),
      .link_out (links[j]),
      .acc_in   (accs[j+1]),
      .acc_out  (accs[j])
    );
  end

  assign head_acc   = accs[0];
  assign tail_valid = links[DLIM-1].valid;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Dense matrix multiply of two stored Q8.8 matrices, exact Q19.16 results.
// Requests with tuser 0 or 1 write one element of A or B at (row, col); they
// give no result, and a row or column outside the store is dropped. A
// request with tuser 2 forms C = A * B using the sizes in the four dimension
// registers (0 reads as 1, values above the store size clip to it). If
// cols_a and rows_b disagree, a single result with tuser 1 and tlast set
// comes out instead. Otherwise C leaves in row-major order, tlast on its
// final element. DLIM is the number of cells (the smaller of MAX_DIM and 8).
// For each product row the A store, which has one read port, feeds one term
// per cycle into the cell chain, the chain then drains until the last term
// has settled in the last cell, and the row is unloaded one element per
// cycle while the output is not stalled. New requests are held off from the
// compute request until its last result is in the output register. Only
// elements that were written may be used.
// ----------------------------------------------------------------------------
`include "matrix_multiply_engine_defines.svh"

module matrix_multiply_engine #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // elem_row[2:0], elem_col[5:3], elem_value[21:6], zero pad
  input  logic [1:0]  s_tuser,   // operation[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // prod_value[34:0], prod_row[37:35], prod_col[40:38], pad
  output logic        m_tuser,   // shape_error[0]
  output logic        m_tlast,
  // dimension registers: 0 rows_a, 1 cols_a, 2 rows_b, 3 cols_b
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int DLIM      = (MAX_DIM < mme_pkg::DIM_CAP) ? MAX_DIM : mme_pkg::DIM_CAP;
  localparam int DEPTH     = DLIM * DLIM;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DRAIN_CYC = DLIM + 2;   // last term to settle in the last cell
  localparam int WW        = $clog2(DRAIN_CYC + 1);
  localparam logic [3:0] DLIM4 = 4'(DLIM);

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_COLS_A = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;
  localparam logic [1:0] REG_COLS_B = 2'd3;

  // request fields
  logic [2:0]                       elem_row;
  logic [2:0]                       elem_col;
  logic signed [mme_pkg::VAL_W-1:0] elem_value;
  logic                             accept;
  logic                             in_store;

  assign elem_row   = s_tdata[2:0];
  assign elem_col   = s_tdata[5:3];
  assign elem_value = s_tdata[21:6];
  assign accept     = s_tvalid && s_tready;
  assign in_store   = ({1'b0, elem_row} < DLIM4) && ({1'b0, elem_col} < DLIM4);

  // dimension registers
  logic [3:0] rows_a, cols_a, rows_b, cols_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= 4'd1;
      cols_a <= 4'd1;
      rows_b <= 4'd1;
      cols_b <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS_A: rows_a <= cfg_data;
        REG_COLS_A: cols_a <= cfg_data;
        REG_ROWS_B: rows_b <= cfg_data;
        REG_COLS_B: cols_b <= cfg_data;
        default:    ;
      endcase
    end
  end

  logic shape_ok;
  assign shape_ok = mme_pkg::eff_dim(cols_a, DLIM4) == mme_pkg::eff_dim(rows_b, DLIM4);

  // sequencer state and loop counters
  mme_pkg::mme_state_t state, state_next;
  logic [3:0]    m_eff, n_eff, q_eff;
  logic [3:0]    i_cnt, k_cnt, j_cnt;
  logic [WW-1:0] wait_cnt;
  logic          out_free;
  logic          row_done;
  logic          last_row;

  assign out_free = !m_tvalid || m_tready;
  assign row_done = (j_cnt + 4'd1) == q_eff;
  assign last_row = (i_cnt + 4'd1) == m_eff;

  always_comb begin
    state_next = state;
    case (state)
      mme_pkg::ST_IDLE: begin
        if (accept && s_tuser == mme_pkg::OP_COMPUTE) begin
          state_next = shape_ok ? mme_pkg::ST_CLEAR : mme_pkg::ST_ERR;
        end
      end
      mme_pkg::ST_CLEAR: state_next = mme_pkg::ST_FEED;
      mme_pkg::ST_FEED: begin
        if ((k_cnt + 4'd1) == n_eff) begin
          state_next = mme_pkg::ST_DRAIN;
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (wait_cnt == WW'(DRAIN_CYC - 1)) begin
          state_next = mme_pkg::ST_EMIT;
        end
      end
      mme_pkg::ST_EMIT: begin
        if (out_free && row_done) begin
          state_next = last_row ? mme_pkg::ST_IDLE : mme_pkg::ST_CLEAR;
        end
      end
      mme_pkg::ST_ERR: begin
        if (out_free) begin
          state_next = mme_pkg::ST_IDLE;
        end
      end
      default: state_next = mme_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mme_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // outputs of the sequencer
  mme_pkg::mme_ctrl_t ctrl;
  logic               rd_en;
  logic               load_res;
  logic               load_err;

  always_comb begin
    s_tready    = (state == mme_pkg::ST_IDLE);
    rd_en       = (state == mme_pkg::ST_FEED);
    load_res    = (state == mme_pkg::ST_EMIT) && out_free;
    load_err    = (state == mme_pkg::ST_ERR) && out_free;
    ctrl.clear  = (state == mme_pkg::ST_CLEAR);
    ctrl.shift  = load_res;
    ctrl.b_we   = accept && (s_tuser == mme_pkg::OP_LOAD_B) && in_store;
    ctrl.b_row  = elem_row;
    ctrl.b_col  = elem_col;
    ctrl.b_data = elem_value;
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == mme_pkg::OP_COMPUTE) begin
      m_eff <= mme_pkg::eff_dim(rows_a, DLIM4);
      n_eff <= mme_pkg::eff_dim(cols_a, DLIM4);
      q_eff <= mme_pkg::eff_dim(cols_b, DLIM4);
      i_cnt <= 4'd0;
    end
    case (state)
      mme_pkg::ST_CLEAR: begin
        k_cnt    <= 4'd0;
        j_cnt    <= 4'd0;
        wait_cnt <= '0;
      end
      mme_pkg::ST_FEED:  k_cnt    <= k_cnt + 4'd1;
      mme_pkg::ST_DRAIN: wait_cnt <= wait_cnt + WW'(1);
      mme_pkg::ST_EMIT: begin
        if (out_free) begin
          j_cnt <= j_cnt + 4'd1;
          if (row_done) begin
            i_cnt <= i_cnt + 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // store of matrix A, one write and one registered read port
  logic signed [mme_pkg::VAL_W-1:0] a_mem [DEPTH];
  logic signed [mme_pkg::VAL_W-1:0] a_rd;
  logic [2:0]                       rd_k;
  logic                             rd_valid;
  logic [AW-1:0]                    wr_idx;
  logic [AW-1:0]                    rd_idx;

  assign wr_idx = AW'(int'(elem_row) * DLIM + int'(elem_col));
  assign rd_idx = AW'(int'(i_cnt) * DLIM + int'(k_cnt));

  always_ff @(posedge clk) begin
    if (accept && s_tuser == mme_pkg::OP_LOAD_A && in_store) begin
      a_mem[wr_idx] <= elem_value;
    end
    if (rd_en) begin
      a_rd <= a_mem[rd_idx];
    end
    rd_k <= k_cnt[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // cell chain, one cell per column of the product row
  mme_pkg::mme_link_t               head_in;
  logic signed [mme_pkg::ACC_W-1:0] head_acc;
  logic                             tail_valid;

  assign head_in.valid = rd_valid;
  assign head_in.k     = rd_k;
  assign head_in.a     = a_rd;

  mme_chain #(
    .DLIM(DLIM)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .head_in    (head_in),
    .head_acc   (head_acc),
    .tail_valid (tail_valid)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_res || load_err) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      m_tdata <= {7'd0, j_cnt[2:0], i_cnt[2:0], head_acc};
      m_tuser <= 1'b0;
      m_tlast <= row_done && last_row;
    end else if (load_err) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
      m_tlast <= 1'b1;
    end
  end

  // checks
  `MME_IMPLY(a_err_is_last, m_tvalid && m_tuser, m_tlast, "shape error result without last")
  `MME_CHECK(a_rd_from_feed, rd_valid |-> $past(state == mme_pkg::ST_FEED), "term read outside feed")
  `MME_IMPLY(a_tail_in_row, tail_valid, state == mme_pkg::ST_FEED || state == mme_pkg::ST_DRAIN, "term in chain after drain")

endmodule
